>>> sv/lsw_pkg.sv
// shared types, constants and helpers for the latency statistics window monitor
// no dependencies
package lsw_pkg;

   localparam int RING_DEPTH = 100;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int FILL_W     = $clog2(RING_DEPTH + 1);

   localparam logic [23:0] PERIOD_RESET = 24'd1000000;
   localparam logic [47:0] MAX48        = {48{1'b1}};
   localparam logic [31:0] MAX32        = {32{1'b1}};
   localparam logic [23:0] MAX24        = {24{1'b1}};

   typedef enum logic [1:0] {
      CMD_HIT   = 2'd0,
      CMD_LOCK  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RING,
      ST_SQ_OLD,
      ST_SQ_D,
      ST_ADD_D,
      ST_NSQ_LO,
      ST_NSQ_HI,
      ST_SUM_SQ,
      ST_VAR,
      ST_SQRT,
      ST_DIV,
      ST_CLOSE
   } seq_state_type;

   // start and finish of one iterative unit
   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return (sum >= {1'b0, MAX48}) ? MAX48 : sum[47:0];
   endfunction

   function automatic logic [31:0] sat_inc32(input logic [31:0] a);
      return (a == MAX32) ? MAX32 : a + 32'd1;
   endfunction

endpackage

>>> sv/lsw_req_if.sv
// input channel: command, duration and timestamp words
// depends on nothing
interface lsw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [23:0] duration_us;
   logic [47:0] now_us;

   modport source (output valid, command, duration_us, now_us, input ready);
   modport sink   (input valid, command, duration_us, now_us, output ready);
endinterface

>>> sv/lsw_rsp_if.sv
// result channel: totals, last window totals, min, max and deviation
// depends on nothing
interface lsw_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] total_hits;
   logic [47:0] total_time_us;
   logic [47:0] total_lock_us;
   logic [31:0] period_hits;
   logic [47:0] period_time_us;
   logic [47:0] period_lock_us;
   logic [23:0] min_us;
   logic [23:0] max_us;
   logic [23:0] stddev_us;

   modport source (output valid, total_hits, total_time_us, total_lock_us, period_hits,
                   period_time_us, period_lock_us, min_us, max_us, stddev_us,
                   input ready);
   modport sink   (input valid, total_hits, total_time_us, total_lock_us, period_hits,
                   period_time_us, period_lock_us, min_us, max_us, stddev_us,
                   output ready);
endinterface

>>> sv/lsw_mul.sv
// shared 32x32 multiplier with registered product
// depends on nothing
module lsw_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] product
);
   logic [63:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= {32'd0, op_a} * {32'd0, op_b};
   end

   assign product = product_ff;
endmodule

>>> sv/lsw_sqrt.sv
// integer square root, one result bit per cycle
// uses lsw_pkg
module lsw_sqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [63:0]          value,
   output lsw_pkg::unit_ctl_type status,
   output logic [31:0]          root
);
   import lsw_pkg::*;

   logic [63:0] v_ff, r_ff, b_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [63:0] trial;

   assign trial = r_ff + b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff <= value;
         r_ff <= '0;
         b_ff <= 64'd1 << 62;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + b_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         b_ff <= b_ff >> 2;
      end
   end

   assign status.start = start;
   assign status.done  = done_ff;
   assign root         = r_ff[31:0];
endmodule

>>> sv/lsw_div.sv
// restoring divider of a 32-bit value by the ring fill, one quotient bit per cycle
// uses lsw_pkg
module lsw_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31:0]          dividend,
   input  logic [lsw_pkg::FILL_W-1:0] divisor,
   output lsw_pkg::unit_ctl_type status,
   output logic [31:0]          quotient
);
   import lsw_pkg::*;

   logic [31:0]       q_ff;
   logic [FILL_W-1:0] rem_ff;
   logic [FILL_W-1:0] dvs_ff;
   logic [4:0]        cnt_ff;
   logic              busy_ff, done_ff;
   logic [FILL_W:0]   trial;

   assign trial = {rem_ff, q_ff[31]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_ff <= FILL_W'(trial - {1'b0, dvs_ff});
            q_ff   <= {q_ff[30:0], 1'b1};
         end else begin
            rem_ff <= trial[FILL_W-1:0];
            q_ff   <= {q_ff[30:0], 1'b0};
         end
      end
   end

   assign status.start = start;
   assign status.done  = done_ff;
   assign quotient     = q_ff;
endmodule

>>> sv/latency_stats_window_monitor_unit.sv
// top level of the windowed latency statistics monitor
// uses lsw_pkg, lsw_req_if, lsw_rsp_if, lsw_mul, lsw_sqrt, lsw_div
//
// channel   direction  words carried
// req       in         command, duration_us, now_us
// rsp       out        all-time totals, last window totals, min, max, stddev
// csr       in         period_us, write only
//
// lock, clear and unused commands answer in the cycle after acceptance
// a hit answers after one ring update, five passes through the shared multiplier, two
//   accumulate steps, the square root, the divider and the window check
// a hit that leaves a single duration in the ring skips the deviation steps and goes straight to the window check
// one word is in flight at a time; req is not ready until rsp is taken
// reset is synchronous, active high; the ring memory itself is not cleared
module latency_stats_window_monitor_unit (
   input  logic        clock,
   input  logic        reset,
   lsw_req_if.sink     req,
   lsw_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);
   import lsw_pkg::*;

   seq_state_type state_ff, state_in;

   // statistics state
   logic [47:0] all_hits_ff, all_time_ff, all_lock_ff;
   logic [31:0] win_hits_ff, last_hits_ff;
   logic [47:0] win_time_ff, win_lock_ff, last_time_ff, last_lock_ff;
   logic [47:0] window_start_ff;
   logic [23:0] min_ff, max_ff, dev_ff;
   logic [23:0] period_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [RING_AW-1:0] slot_ff;
   logic [30:0] sum_ff;
   logic [54:0] sq_ff;

   // per-hit working registers
   logic [23:0] dur_ff;
   logic [47:0] now_ff;
   logic        full_ff;
   logic [63:0] acc_ff;
   logic        rsp_valid_ff;

   // ring memory
   logic [23:0] ring_mem [RING_DEPTH];
   logic [23:0] ring_rd_ff;
   logic        ring_we;
   logic [RING_AW-1:0] ring_addr;

   // shared units
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic        sqrt_start, div_start;
   unit_ctl_type sqrt_st, div_st;
   logic [31:0] sqrt_root, div_q;
   logic [23:0] old_val;
   logic [47:0] elapsed;
   logic        accept;
   logic [1:0]  cmd_bits;
   cmd_type     cmd;

   assign accept   = req.valid && req.ready;
   assign cmd_bits = req.command;
   assign cmd      = cmd_type'(cmd_bits);
   assign old_val  = full_ff ? ring_rd_ff : 24'd0;
   assign elapsed  = (now_ff >= window_start_ff) ? now_ff - window_start_ff : 48'd0;

   lsw_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   lsw_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sqrt_start),
      .value  (acc_ff - mul_p),
      .status (sqrt_st),
      .root   (sqrt_root)
   );

   lsw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sqrt_root),
      .divisor  (fill_ff),
      .status   (div_st),
      .quotient (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept && cmd == CMD_HIT) state_in = ST_RING;
         ST_RING:   state_in = ST_SQ_OLD;
         ST_SQ_OLD: state_in = ST_SQ_D;
         ST_SQ_D:   state_in = ST_ADD_D;
         ST_ADD_D:  state_in = (fill_ff > FILL_W'(1)) ? ST_NSQ_LO : ST_CLOSE;
         ST_NSQ_LO: state_in = ST_NSQ_HI;
         ST_NSQ_HI: state_in = ST_SUM_SQ;
         ST_SUM_SQ: state_in = ST_VAR;
         ST_VAR:    state_in = ST_SQRT;
         ST_SQRT:   if (sqrt_st.done) state_in = ST_DIV;
         ST_DIV:    if (div_st.done) state_in = ST_CLOSE;
         ST_CLOSE:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // unit operands, starts and memory control
   always_comb begin
      mul_a      = '0;
      mul_b      = '0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      ring_we    = 1'b0;
      ring_addr  = slot_ff;
      unique case (state_ff)
         ST_RING: begin
            ring_we   = 1'b1;
            ring_addr = (fill_ff < FILL_W'(RING_DEPTH)) ? fill_ff[RING_AW-1:0] : slot_ff;
         end
         ST_SQ_OLD: begin
            mul_a = {8'd0, old_val};
            mul_b = {8'd0, old_val};
         end
         ST_SQ_D: begin
            mul_a = {8'd0, dur_ff};
            mul_b = {8'd0, dur_ff};
         end
         ST_NSQ_LO: begin
            mul_a = sq_ff[31:0];
            mul_b = 32'(fill_ff);
         end
         ST_NSQ_HI: begin
            mul_a = {9'd0, sq_ff[54:32]};
            mul_b = 32'(fill_ff);
         end
         ST_SUM_SQ: begin
            mul_a = {1'b0, sum_ff};
            mul_b = {1'b0, sum_ff};
         end
         ST_VAR:  sqrt_start = 1'b1;
         ST_SQRT: div_start  = sqrt_st.done;
         default: begin
         end
      endcase
   end

   // ring memory, read before write at the same slot
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_rd_ff           <= ring_mem[ring_addr];
         ring_mem[ring_addr]  <= dur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         dur_ff <= req.duration_us;
         now_ff <= req.now_us;
      end
      unique case (state_ff)
         ST_RING:   full_ff <= (fill_ff >= FILL_W'(RING_DEPTH));
         ST_NSQ_HI: acc_ff  <= mul_p;
         ST_SUM_SQ: acc_ff  <= acc_ff + {mul_p[31:0], 32'd0};
         default: begin
         end
      endcase
   end

   // statistics state and response handshake
   always_ff @(posedge clock) begin
      if (reset || (accept && cmd == CMD_CLEAR)) begin
         all_hits_ff     <= '0;
         all_time_ff     <= '0;
         all_lock_ff     <= '0;
         win_hits_ff     <= '0;
         win_time_ff     <= '0;
         win_lock_ff     <= '0;
         last_hits_ff    <= '0;
         last_time_ff    <= '0;
         last_lock_ff    <= '0;
         window_start_ff <= '0;
         min_ff          <= MAX24;
         max_ff          <= '0;
         dev_ff          <= '0;
         fill_ff         <= '0;
         slot_ff         <= '0;
         sum_ff          <= '0;
         sq_ff           <= '0;
         rsp_valid_ff    <= !reset;
      end else begin
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (cmd)
                     CMD_HIT: begin
                        all_time_ff <= sat_add48(all_time_ff, {24'd0, req.duration_us});
                        win_time_ff <= sat_add48(win_time_ff, {24'd0, req.duration_us});
                        all_hits_ff <= sat_add48(all_hits_ff, 48'd1);
                        win_hits_ff <= sat_inc32(win_hits_ff);
                        if (req.duration_us > max_ff) max_ff <= req.duration_us;
                        if (req.duration_us < min_ff) min_ff <= req.duration_us;
                     end
                     CMD_LOCK: begin
                        all_lock_ff  <= sat_add48(all_lock_ff, {24'd0, req.duration_us});
                        win_lock_ff  <= sat_add48(win_lock_ff, {24'd0, req.duration_us});
                        rsp_valid_ff <= 1'b1;
                     end
                     CMD_CLEAR, CMD_NONE: rsp_valid_ff <= 1'b1;
                  endcase
               end
            end
            ST_RING: begin
               // fill mode appends; full mode overwrites the oldest slot
               if (fill_ff < FILL_W'(RING_DEPTH)) begin
                  fill_ff <= fill_ff + FILL_W'(1);
               end else begin
                  slot_ff <= (slot_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : slot_ff + RING_AW'(1);
               end
            end
            ST_SQ_OLD: sum_ff <= sum_ff - {7'd0, old_val} + {7'd0, dur_ff};
            ST_SQ_D:   sq_ff  <= sq_ff - mul_p[54:0];
            ST_ADD_D:  sq_ff  <= sq_ff + mul_p[54:0];
            ST_DIV:    if (div_st.done) dev_ff <= div_q[23:0];
            ST_CLOSE: begin
               if (elapsed >= {24'd0, period_ff}) begin
                  // a window that ran two periods or more reports nothing
                  if (elapsed < {23'd0, period_ff, 1'b0}) begin
                     last_hits_ff <= win_hits_ff;
                     last_time_ff <= win_time_ff;
                     last_lock_ff <= win_lock_ff;
                  end else begin
                     last_hits_ff <= '0;
                     last_time_ff <= '0;
                     last_lock_ff <= '0;
                  end
                  window_start_ff <= now_ff;
                  win_hits_ff     <= '0;
                  win_time_ff     <= '0;
                  win_lock_ff     <= '0;
                  fill_ff         <= '0;
                  slot_ff         <= '0;
                  sum_ff          <= '0;
                  sq_ff           <= '0;
               end
               rsp_valid_ff <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign req.ready          = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.total_hits     = all_hits_ff;
   assign rsp.total_time_us  = all_time_ff;
   assign rsp.total_lock_us  = all_lock_ff;
   assign rsp.period_hits    = last_hits_ff;
   assign rsp.period_time_us = last_time_ff;
   assign rsp.period_lock_us = last_lock_ff;
   assign rsp.min_us         = min_ff;
   assign rsp.max_us         = max_ff;
   assign rsp.stddev_us      = dev_ff;
endmodule

>>> sv/lsw_checker.sv
// port-level checks for the latency statistics window monitor, bound to the top level
// depends on latency_stats_window_monitor_unit
module lsw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [47:0] total_hits,
   input logic [23:0] min_us,
   input logic [23:0] max_us
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("req word taken while a result waits");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && total_hits != 48'd0 |-> min_us <= max_us)
      else $error("min above max after a hit");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");
endmodule

bind latency_stats_window_monitor_unit lsw_checker u_lsw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .total_hits (rsp.total_hits),
   .min_us     (rsp.min_us),
   .max_us     (rsp.max_us)
);

>>> tb/lsw_tb_if.sv
`timescale 1ns / 100ps
// testbench copy of nothing: the channels come from the rtl interface files
// this file holds the shared word types used by the testbench top
// depends on lsw_pkg
package lsw_tb_pkg;
   import lsw_pkg::*;

   typedef struct packed {
      cmd_type     command;
      logic [23:0] duration_us;
      logic [47:0] now_us;
   } req_word_type;

   typedef struct packed {
      logic [47:0] total_hits;
      logic [47:0] total_time_us;
      logic [47:0] total_lock_us;
      logic [31:0] period_hits;
      logic [47:0] period_time_us;
      logic [47:0] period_lock_us;
      logic [23:0] min_us;
      logic [23:0] max_us;
      logic [23:0] stddev_us;
   } stats_word_type;
endpackage

>>> tb/latency_stats_window_monitor_unit_tb.sv
`timescale 1ns / 100ps
// testbench for latency_stats_window_monitor_unit: random and directed words with a
// built-in statistics predictor; depends on lsw_pkg, lsw_tb_pkg and the rtl interfaces
module latency_stats_window_monitor_unit_tb;
   import lsw_pkg::*;
   import lsw_tb_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [23:0] csr_wr_data = '0;

   lsw_req_if req ();
   lsw_rsp_if rsp ();

   latency_stats_window_monitor_unit DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [23:0]  window_len;
   logic [47:0]  sum_hits, sum_time, sum_lock;
   logic [31:0]  open_hits;
   logic [47:0]  open_time, open_lock;
   logic [31:0]  closed_hits;
   logic [47:0]  closed_time, closed_lock;
   logic [47:0]  open_start;
   logic [23:0]  shortest, longest, spread;
   logic [23:0]  recent [RING_DEPTH];
   int unsigned  recent_count, recent_next;
   logic [63:0]  recent_sum, recent_sq;

   req_word_type   pending_words[$];
   stats_word_type expected_stats[$];

   int  error_count = 0;
   int  idle_pct = 0;     // sender idle percent
   int  stall_pct = 0;    // receiver stall percent
   int  hold_cycles = 0;  // long receiver hold-off
   int  quiet_cycles = 0;
   bit  stim_done = 0;

   function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? {48{1'b1}} : s[47:0];
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic clear_stats();
      sum_hits = 0; sum_time = 0; sum_lock = 0;
      open_hits = 0; open_time = 0; open_lock = 0;
      closed_hits = 0; closed_time = 0; closed_lock = 0;
      open_start = 0; shortest = '1; longest = 0; spread = 0;
      recent_count = 0; recent_next = 0; recent_sum = 0; recent_sq = 0;
   endtask

   // one hit: totals, ring, min/max, deviation, then window close check
   task automatic record_hit(logic [23:0] d, logic [47:0] now);
      logic [63:0] old, n, var_n2, elapsed;
      sum_time = add_sat48(sum_time, {24'd0, d});
      open_time = add_sat48(open_time, {24'd0, d});
      sum_hits = add_sat48(sum_hits, 48'd1);
      if (open_hits != '1) open_hits = open_hits + 1;
      if (recent_count < RING_DEPTH) begin
         recent[recent_count] = d;
         recent_count++;
      end else begin
         old = recent[recent_next];
         recent_sum -= old;
         recent_sq -= old * old;
         recent[recent_next] = d;
         recent_next = (recent_next + 1 < RING_DEPTH) ? recent_next + 1 : 0;
      end
      recent_sum += d;
      recent_sq += 64'(d) * 64'(d);
      if (d > longest) longest = d;
      if (d < shortest) shortest = d;
      if (recent_count > 1) begin
         n = recent_count;
         var_n2 = n * recent_sq - recent_sum * recent_sum;
         spread = 24'(root_floor(var_n2) / n);
      end
      elapsed = (now >= open_start) ? 64'(now - open_start) : 0;
      if (elapsed >= window_len) begin
         if (elapsed < 2 * 64'(window_len)) begin
            closed_hits = open_hits; closed_time = open_time; closed_lock = open_lock;
         end else begin
            closed_hits = 0; closed_time = 0; closed_lock = 0;
         end
         open_start = now;
         open_hits = 0; open_time = 0; open_lock = 0;
         recent_count = 0; recent_next = 0; recent_sum = 0; recent_sq = 0;
      end
   endtask

   task automatic predict_stats(req_word_type w);
      stats_word_type s;
      case (w.command)
         CMD_HIT:   record_hit(w.duration_us, w.now_us);
         CMD_LOCK: begin
            open_lock = add_sat48(open_lock, {24'd0, w.duration_us});
            sum_lock = add_sat48(sum_lock, {24'd0, w.duration_us});
         end
         CMD_CLEAR: clear_stats();
         default: ;
      endcase
      s.total_hits = sum_hits; s.total_time_us = sum_time; s.total_lock_us = sum_lock;
      s.period_hits = closed_hits; s.period_time_us = closed_time;
      s.period_lock_us = closed_lock;
      s.min_us = shortest; s.max_us = longest; s.stddev_us = spread;
      expected_stats.push_back(s);
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // driver: offers queued words, idles at random
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_word_type w;
            w = pending_words.pop_front();
            req.valid <= 1'b1;
            req.command <= w.command;
            req.duration_us <= w.duration_us;
            req.now_us <= w.now_us;
            predict_stats(w);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // receiver readiness, with an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor: compares each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_stats.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            stats_word_type e;
            e = expected_stats.pop_front();
            if (rsp.total_hits !== e.total_hits)
               report_mismatch("total_hits", rsp.total_hits, e.total_hits);
            if (rsp.total_time_us !== e.total_time_us)
               report_mismatch("total_time_us", rsp.total_time_us, e.total_time_us);
            if (rsp.total_lock_us !== e.total_lock_us)
               report_mismatch("total_lock_us", rsp.total_lock_us, e.total_lock_us);
            if (rsp.period_hits !== e.period_hits)
               report_mismatch("period_hits", rsp.period_hits, e.period_hits);
            if (rsp.period_time_us !== e.period_time_us)
               report_mismatch("period_time_us", rsp.period_time_us, e.period_time_us);
            if (rsp.period_lock_us !== e.period_lock_us)
               report_mismatch("period_lock_us", rsp.period_lock_us, e.period_lock_us);
            if (rsp.min_us !== e.min_us) report_mismatch("min_us", rsp.min_us, e.min_us);
            if (rsp.max_us !== e.max_us) report_mismatch("max_us", rsp.max_us, e.max_us);
            if (rsp.stddev_us !== e.stddev_us)
               report_mismatch("stddev_us", rsp.stddev_us, e.stddev_us);
         end
      end
   end

   // watchdog: cycles with no word accepted on either side
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (pending_words.size() > 0 || expected_stats.size() > 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000) begin
            $display("[latency_stats_window_monitor_unit] ERROR");
            $finish;
         end
      end
   end

   function automatic req_word_type make_word(cmd_type c, logic [23:0] d, logic [47:0] t);
      req_word_type w;
      w.command = c; w.duration_us = d; w.now_us = t;
      return w;
   endfunction

   // wait until all words are taken and answered, then a short settle
   task automatic drain();
      while (pending_words.size() > 0 || expected_stats.size() > 0 || req.valid)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_period(logic [23:0] p);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      window_len = p;
   endtask

   // mostly hit words with mostly rising timestamps, some lock, clear and unused words
   task automatic random_phase(int count, int ipct, int spct, int max_step);
      logic [47:0] t;
      logic [23:0] d;
      int k;
      idle_pct = ipct;
      stall_pct = spct;
      t = 48'({$urandom, $urandom});
      if ($urandom_range(3) != 0) t = 48'($urandom_range(1000));
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         case ($urandom_range(3))
            0: d = 24'($urandom);
            1: d = 24'($urandom_range(255));
            2: d = MAX24 - 24'($urandom_range(3));
            default: d = 24'($urandom_range(100000));
         endcase
         if ($urandom_range(19) == 0) t = t - 48'($urandom_range(max_step));
         else t = t + 48'($urandom_range(max_step));
         if ($urandom_range(49) == 0) t = 48'({$urandom, $urandom});
         if (k < 75) pending_words.push_back(make_word(CMD_HIT, d, t));
         else if (k < 92) pending_words.push_back(make_word(CMD_LOCK, d, t));
         else if (k < 96) pending_words.push_back(make_word(CMD_CLEAR, d, t));
         else pending_words.push_back(make_word(CMD_NONE, d, t));
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.command = CMD_NONE;
      req.duration_us = '0;
      req.now_us = '0;
      rsp.ready = 1'b0;
      window_len = PERIOD_RESET;
      clear_stats();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, window cases, long hold-off
      pending_words.push_back(make_word(CMD_NONE, '1, '1));
      pending_words.push_back(make_word(CMD_HIT, 24'd0, 48'd5));
      pending_words.push_back(make_word(CMD_HIT, '1, 48'd10));
      pending_words.push_back(make_word(CMD_HIT, 24'd7, 48'd20));
      pending_words.push_back(make_word(CMD_LOCK, '1, 48'd30));
      pending_words.push_back(make_word(CMD_LOCK, 24'd0, '1));
      pending_words.push_back(make_word(CMD_HIT, 24'd3, 48'd1500000)); // close in one period
      pending_words.push_back(make_word(CMD_HIT, 24'd4, 48'd1000)); // time behind start
      pending_words.push_back(make_word(CMD_HIT, 24'd9, 48'd9000000)); // two periods late
      pending_words.push_back(make_word(CMD_CLEAR, '1, '0));
      pending_words.push_back(make_word(CMD_HIT, 24'h555555, 48'hAAAA_AAAA_AAAA));
      pending_words.push_back(make_word(CMD_HIT, 24'hAAAAAA, 48'h5555_5555_5555));
      hold_cycles = 400;
      drain();

      // full ring wrap within one long window
      write_period('1);
      for (int i = 0; i < 230; i++)
         pending_words.push_back(make_word(CMD_HIT, 24'($urandom), 48'(i)));
      drain();

      // zero period: every hit closes with zeroed last-period outputs
      write_period(24'd0);
      random_phase(120, 0, 0, 50);
      drain();
      write_period(24'd1);
      random_phase(150, 46, 0, 3);
      drain();
      write_period(24'd200);
      random_phase(400, 0, 46, 60);
      drain();
      write_period(24'd5000);
      random_phase(400, 31, 31, 1500);
      drain();
      write_period('1);
      random_phase(200, 0, 0, 5000000);
      hold_cycles = 500;
      drain();

      // back to the reset period from a cleared start
      write_period(PERIOD_RESET);
      pending_words.push_back(make_word(CMD_CLEAR, '0, '0));
      random_phase(237, 0, 0, 1000);
      drain();

      if (error_count == 0) begin
         $display("[latency_stats_window_monitor_unit] OK");
      end else begin
         $display("[latency_stats_window_monitor_unit] ERROR");
      end
      $finish;
   end
endmodule
